// File: hdl/mpq_pkg.sv
// Package for the min priority queue: payload structs, cell record and codes.
// Used by every module of the block; it depends on nothing.
package mpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 7;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic                    op;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic signed [KEY_W-1:0] min_key;
    logic [COUNT_W-1:0]      count;
    logic                    is_empty;
    logic [1:0]              status;
  } out_t;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
  } cell_t;

  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [KEY_W-1:0] key;
  } cmd_t;

endpackage

// File: hdl/mpq_cell.sv
// One cell of the sorted chain: holds one key and its valid bit.
// Depends on mpq_pkg; the chain is built in min_priority_queue_unit.
module mpq_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  mpq_pkg::cmd_t cmd,
  input  mpq_pkg::cell_t left_q,
  input  logic          left_gt,
  input  mpq_pkg::cell_t right_q,
  output mpq_pkg::cell_t cell_q,
  output logic          gt
);
  import mpq_pkg::*;

  cell_t cell_r;
  cell_t cell_nxt;

  assign gt = !cell_r.valid || (cmd.key < cell_r.key);

  always_comb begin
    cell_nxt = cell_r;
    if (cmd.ins) begin
      if (gt) begin
        if (left_gt) begin
          cell_nxt = left_q;
        end else begin
          cell_nxt.valid = 1'b1;
          cell_nxt.key   = cmd.key;
        end
      end
    end else if (cmd.rem) begin
      cell_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r.key <= cell_nxt.key;
  end

  assign cell_q = cell_r;

endmodule

// File: hdl/min_priority_queue_unit.sv
// Min priority queue: a sorted chain of cells with the smallest key in the head cell.
// The result is registered in the cycle after the input transfer; one item is taken every cycle
// while the result register is free or being drained.
// Synchronous active-low reset clears every valid bit, the count and the result valid flag.
// Depends on mpq_pkg and mpq_cell.
module min_priority_queue_unit #(
  parameter int CAPACITY = mpq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mpq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mpq_pkg::out_t out_data
);
  import mpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  cell_t cell_q [CAPACITY];
  logic  gt     [CAPACITY];
  cmd_t  cmd;
  cell_t head_nxt;
  logic  accept;
  logic  full;
  logic  empty;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CNT_W+COUNT_W-1:0] count_ext;
  logic                     out_valid_r;
  out_t                     out_r;
  out_t                     out_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = cell_q[CAPACITY-1].valid;
  assign empty    = !cell_q[0].valid;

  assign cmd.ins = accept && (in_data.op == OP_INSERT) && !full;
  assign cmd.rem = accept && (in_data.op == OP_REMOVE) && !empty;
  assign cmd.key = in_data.key;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_t left_q;
    cell_t right_q;
    logic  left_gt;
    if (i == 0) begin : g_head
      assign left_q  = '0;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_q  = cell_q[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_q = '0;
    end else begin : g_mid
      assign right_q = cell_q[i+1];
    end
    mpq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .left_q  (left_q),
      .left_gt (left_gt),
      .right_q (right_q),
      .cell_q  (cell_q[i]),
      .gt      (gt[i])
    );
  end

  always_comb begin
    head_nxt = cell_q[0];
    if (cmd.ins && gt[0]) begin
      head_nxt.valid = 1'b1;
      head_nxt.key   = cmd.key;
    end else if (cmd.rem) begin
      head_nxt = cell_q[1];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    out_nxt.removed_key = cmd.rem ? cell_q[0].key : '0;
    out_nxt.min_key     = head_nxt.valid ? head_nxt.key : '0;
    out_nxt.count       = count_ext[COUNT_W-1:0];
    out_nxt.is_empty    = !head_nxt.valid;
    out_nxt.status      = ST_OK;
    if ((in_data.op == OP_INSERT) && full) begin
      out_nxt.status = ST_FULL;
    end else if ((in_data.op == OP_REMOVE) && empty) begin
      out_nxt.status = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/mpq_checker.sv
// Port-level checks for min_priority_queue_unit, attached by the bind below.
// Depends on mpq_pkg and on the top level's port names.
module mpq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input mpq_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input mpq_pkg::out_t out_data
);
  import mpq_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted item gave no result.");

  a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> out_data.min_key == 0)
    else $error("Empty result shows a minimum key.");

  a_empty_remove: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.is_empty && out_data.removed_key == 0)
    else $error("Remove on empty left a bad result.");

endmodule

bind min_priority_queue_unit mpq_checker u_mpq_checker (.*);

// File: sim/min_priority_queue_unit_test.sv
// Testbench for min_priority_queue_unit: drives random and directed insert/remove transfers
// and checks every result against a cell-array model of the queue kept in a scoreboard class.
// Depends on mpq_pkg and the min_priority_queue_unit RTL.
module min_priority_queue_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_ITEMS = 950;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE       = 4;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  localparam int PH_FILL   = 0;
  localparam int PH_NARROW = 1;
  localparam int PH_DRAIN  = 2;
  localparam int PH_MIXED  = 3;

  class min_queue_scoreboard;
    logic signed [KEY_W-1:0] cell_key [CAPACITY_DEF];
    bit                      cell_used [CAPACITY_DEF];
    int unsigned             stored;
    out_t                    pending_results[$];
    int unsigned             error_count;
    int unsigned             checked_count;
    int unsigned             insert_count;
    int unsigned             drop_count;
    int unsigned             remove_count;
    int unsigned             empty_remove_count;
    int unsigned             peak_stored;

    function new();
      foreach (cell_used[i]) cell_used[i] = 1'b0;
      stored = 0;
      error_count = 0;
      checked_count = 0;
      insert_count = 0;
      drop_count = 0;
      remove_count = 0;
      empty_remove_count = 0;
      peak_stored = 0;
    endfunction

    function int smallest_cell();
      int best;
      best = -1;
      for (int i = 0; i < CAPACITY_DEF; i++) begin
        if (cell_used[i] && (best < 0 || cell_key[i] < cell_key[best])) begin
          best = i;
        end
      end
      return best;
    endfunction

    function void note_input(in_t item);
      out_t want;
      int   slot;
      want = '0;
      want.status = ST_OK;
      if (item.op == OP_INSERT) begin
        insert_count++;
        if (stored >= CAPACITY_DEF) begin
          want.status = ST_FULL;
          drop_count++;
        end else begin
          slot = 0;
          while (cell_used[slot]) slot++;
          cell_key[slot] = item.key;
          cell_used[slot] = 1'b1;
          stored++;
          if (stored > peak_stored) peak_stored = stored;
        end
      end else begin
        remove_count++;
        slot = smallest_cell();
        if (slot < 0) begin
          want.status = ST_EMPTY;
          empty_remove_count++;
        end else begin
          want.removed_key = cell_key[slot];
          cell_used[slot] = 1'b0;
          stored--;
        end
      end
      slot = smallest_cell();
      want.min_key = (slot >= 0) ? cell_key[slot] : '0;
      want.count = stored[COUNT_W-1:0];
      want.is_empty = (stored == 0);
      pending_results.insert(pending_results.size(), want);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        $error("Result transfer with nothing outstanding: %p", got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      checked_count++;
      if (got.removed_key !== want.removed_key) begin
        $error("removed_key: expected %0d, got %0d", want.removed_key, got.removed_key);
        error_count++;
      end
      if (got.min_key !== want.min_key) begin
        $error("min_key: expected %0d, got %0d", want.min_key, got.min_key);
        error_count++;
      end
      if (got.count !== want.count) begin
        $error("count: expected %0d, got %0d", want.count, got.count);
        error_count++;
      end
      if (got.is_empty !== want.is_empty) begin
        $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  bit recv_idle_on = 1'b1;
  min_queue_scoreboard sb = new();

  min_priority_queue_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic send_item(input in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(item);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [KEY_W-1:0] draw_key(input bit narrow);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    if (narrow || pick < 3) return $signed($urandom_range(0, 15)) - 8;
    return $urandom;
  endfunction

  initial begin
    int unsigned holds_done;
    int          wait_cycles;
    holds_done = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      wait_cycles = recv_idle_on ? $urandom_range(0, 4) : 0;
      if (holds_done < 2 && sb.checked_count >= 250 * (holds_done + 1)) begin
        wait_cycles = HOLD_CYCLES;
        holds_done++;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin
    in_t         item;
    int unsigned sent;
    int          phase;
    int          kind;
    int          len;
    int          insert_pct;
    bit          send_idle;
    logic signed [KEY_W-1:0] directed_keys[8];

    directed_keys = '{'0, KEY_MIN, KEY_MAX, '1, 32'sd1, '1, 32'sh5555_5555, 32'shAAAA_AAAA};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    item.op = OP_REMOVE;
    item.key = '1;
    send_item(item, 0);
    foreach (directed_keys[i]) begin
      item.op = OP_INSERT;
      item.key = directed_keys[i];
      send_item(item, i % 2);
    end
    for (int i = 0; i < 9; i++) begin
      item.op = OP_REMOVE;
      item.key = (i % 2) ? '1 : '0;
      send_item(item, 0);
    end
    wait_for_results();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      kind = phase % 4;
      len = $urandom_range(100, 180);
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle_on = ($urandom_range(0, 2) != 0);
      case (kind)
        PH_FILL:   insert_pct = 92;
        PH_DRAIN:  insert_pct = 12;
        PH_NARROW: insert_pct = 55;
        PH_MIXED:  insert_pct = 50;
        default:   insert_pct = 50;
      endcase
      for (int i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        item.op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        item.key = (item.op == OP_INSERT) ? draw_key(kind == PH_NARROW) : $urandom;
        send_item(item, send_idle ? $urandom_range(0, 4) : 0);
        sent++;
      end
      if (phase % 2 == 1) wait_for_results();
      phase++;
    end

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d inserts (%0d dropped while full) and %0d removes (%0d on empty).",
             sb.insert_count, sb.drop_count, sb.remove_count, sb.empty_remove_count);
    $display("Peak occupancy %0d of %0d cells; %0d results checked, %0d mismatches.",
             sb.peak_stored, CAPACITY_DEF, sb.checked_count, sb.error_count);
    if (sb.error_count == 0) begin
      $display("min_priority_queue_unit_test OK");
    end else begin
      $display("min_priority_queue_unit_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("min_priority_queue_unit_test NOT OK");
    $finish;
  end

endmodule
